>>> src/ipv6rlc_pkg.sv
// ----------------------------------------------------------------------------
// ipv6rlc_pkg
// Shared types and constants of the IPv6 range list checker.
// ----------------------------------------------------------------------------
package ipv6rlc_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned ADDR_W      = 128;
  localparam int unsigned INDEX_W     = 32;

  localparam logic [CFG_INDEX_W-1:0] CFG_EXPECTED_LOW  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_EXPECTED_HIGH = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_CLAIMS_ORDER  = 2'd2;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_BAD_RANGE = 2'd1;
  localparam logic [1:0] STATUS_MISMATCH  = 2'd2;
  localparam logic [1:0] STATUS_UNORDERED = 2'd3;

  typedef struct packed {
    logic [63:0] start_low;
    logic [63:0] start_high;
    logic [63:0] end_low;
    logic [63:0] end_high;
    logic        no_record;
    logic        final_item;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] bad_index;
    logic        list_ordered;
  } out_item_t;

  // classified record handed from front to back
  typedef struct packed {
    logic              is_record;
    logic              last;
    logic              bad;
    logic              disorder;
    logic [ADDR_W-1:0] size;
  } work_item_t;

endpackage

>>> src/ipv6_range_list_checker_top.sv
// ----------------------------------------------------------------------------
// ipv6_range_list_checker_top
// Checks a streamed list of IPv6 ranges and reports one status per list.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_stall/in_data carries one range per beat; the
// beat with final_item set closes the list. A beat with no_record set adds
// no range and only serves to carry the final mark, e.g. for an empty list.
// Output channel out_valid/out_stall/out_data carries one status beat per
// list, nothing for other beats.
// The cfg_we/cfg_index/cfg_data port writes the expected total (low and high
// halves) and the ordered claim; write it only while no list is in flight.
// Throughput is one beat per cycle while in_stall is low. The final input
// beat passes through a queue entry, then the accumulator and snapshot
// register, then the status compare and output register.
// The front and back are parted by a QUEUE_DEPTH-entry queue; a stalled
// output fills the snapshot, output register and queue, after which
// in_stall rises. The output register holds its beat while out_stall is high.
// Synchronous reset clears the configuration, the list state and all queued
// beats; no clearing pass is needed afterwards.
// ----------------------------------------------------------------------------
module ipv6_range_list_checker_top #(
  parameter int unsigned QUEUE_DEPTH = ipv6rlc_pkg::QUEUE_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [ipv6rlc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ipv6rlc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  ipv6rlc_pkg::in_item_t               in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output ipv6rlc_pkg::out_item_t              out_data
);

  ipv6rlc_pkg::work_item_t push_item;
  ipv6rlc_pkg::work_item_t pop_item;
  logic                    push_valid;
  logic                    push_ready;
  logic                    pop_valid;
  logic                    pop_ready;

  ipv6rlc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  ipv6rlc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  ipv6rlc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

>>> src/ipv6rlc_front.sv
// ----------------------------------------------------------------------------
// ipv6rlc_front
// Accepts range beats, checks start against end and against the previous
// end, and computes the range size.
// ----------------------------------------------------------------------------
module ipv6rlc_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  ipv6rlc_pkg::in_item_t   in_data,
  output logic                    push_valid,
  input  logic                    push_ready,
  output ipv6rlc_pkg::work_item_t push_item
);

  logic [ipv6rlc_pkg::ADDR_W-1:0] prev_end_r, prev_end_nxt;
  logic [ipv6rlc_pkg::ADDR_W-1:0] prev_inc_r, prev_inc_nxt;
  logic                           prev_max_r, prev_max_nxt;
  logic                           have_prev_r, have_prev_nxt;

  logic [ipv6rlc_pkg::ADDR_W-1:0] start_a;
  logic [ipv6rlc_pkg::ADDR_W-1:0] end_a;
  logic                           is_record;
  logic                           accept;
  logic                           overlap;
  logic                           adjacent;

  assign start_a   = {in_data.start_high, in_data.start_low};
  assign end_a     = {in_data.end_high, in_data.end_low};
  assign is_record = !in_data.no_record;
  assign in_stall  = !push_ready;
  assign accept    = in_valid && push_ready;

  assign overlap  = (prev_end_r >= start_a);
  assign adjacent = !prev_max_r && (prev_inc_r == start_a);

  always_comb begin
    push_valid          = in_valid;
    push_item.is_record = is_record;
    push_item.last      = in_data.final_item;
    push_item.bad       = (end_a < start_a);
    push_item.disorder  = have_prev_r && (overlap || adjacent);
    push_item.size      = end_a - start_a + ipv6rlc_pkg::ADDR_W'(1);
  end

  always_comb begin
    prev_end_nxt  = prev_end_r;
    prev_inc_nxt  = prev_inc_r;
    prev_max_nxt  = prev_max_r;
    have_prev_nxt = have_prev_r;
    if (accept) begin
      if (is_record) begin
        prev_end_nxt  = end_a;
        prev_inc_nxt  = end_a + ipv6rlc_pkg::ADDR_W'(1);
        prev_max_nxt  = &end_a;
        have_prev_nxt = 1'b1;
      end
      if (in_data.final_item) begin
        have_prev_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_prev_r <= 1'b0;
    end else begin
      have_prev_r <= have_prev_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prev_end_r <= prev_end_nxt;
    prev_inc_r <= prev_inc_nxt;
    prev_max_r <= prev_max_nxt;
  end

endmodule

>>> src/ipv6rlc_queue.sv
// ----------------------------------------------------------------------------
// ipv6rlc_queue
// Short first-in first-out queue of classified records between front and back.
// ----------------------------------------------------------------------------
module ipv6rlc_queue #(
  parameter int unsigned DEPTH = ipv6rlc_pkg::QUEUE_DEPTH
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push_valid,
  output logic                    push_ready,
  input  ipv6rlc_pkg::work_item_t push_item,
  output logic                    pop_valid,
  input  logic                    pop_ready,
  output ipv6rlc_pkg::work_item_t pop_item
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  ipv6rlc_pkg::work_item_t entries_r [DEPTH];

  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count_r != FULL_CNT);
  assign pop_valid  = (count_r != '0);
  assign pop_item   = entries_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

>>> src/ipv6rlc_back.sv
// ----------------------------------------------------------------------------
// ipv6rlc_back
// Holds the configuration, accumulates the list state, and forms the status
// beat of each finished list.
// ----------------------------------------------------------------------------
module ipv6rlc_back (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       cfg_we,
  input  logic [ipv6rlc_pkg::CFG_INDEX_W-1:0]        cfg_index,
  input  logic [ipv6rlc_pkg::CFG_DATA_W-1:0]         cfg_data,
  input  logic                                       pop_valid,
  output logic                                       pop_ready,
  input  ipv6rlc_pkg::work_item_t                    pop_item,
  output logic                                       out_valid,
  input  logic                                       out_stall,
  output ipv6rlc_pkg::out_item_t                     out_data
);

  localparam int unsigned AW = ipv6rlc_pkg::ADDR_W;
  localparam int unsigned IW = ipv6rlc_pkg::INDEX_W;

  logic [63:0]   exp_low_r;
  logic [63:0]   exp_high_r;
  logic          claims_r;

  logic [AW-1:0] total_r, total_nxt;
  logic [IW-1:0] count_r, count_nxt;
  logic [IW-1:0] first_bad_r, first_bad_nxt;
  logic          saw_bad_r, saw_bad_nxt;
  logic          ordered_r, ordered_nxt;

  logic [AW-1:0] snap_total_r;
  logic [IW-1:0] snap_first_bad_r;
  logic          snap_saw_bad_r;
  logic          snap_ordered_r;
  logic          snap_valid_r;

  ipv6rlc_pkg::out_item_t out_data_r, out_data_nxt;
  logic                   out_valid_r;

  logic out_ready;
  logic snap_ready;
  logic pop;
  logic take;
  logic finish;

  assign out_ready  = !out_valid_r || !out_stall;
  assign snap_ready = !snap_valid_r || out_ready;
  assign pop_ready  = !pop_item.last || snap_ready;
  assign pop        = pop_valid && pop_ready;
  assign take       = pop && pop_item.is_record;
  assign finish     = pop && pop_item.last;
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_low_r  <= '0;
      exp_high_r <= '0;
      claims_r   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ipv6rlc_pkg::CFG_EXPECTED_LOW:  exp_low_r  <= cfg_data;
        ipv6rlc_pkg::CFG_EXPECTED_HIGH: exp_high_r <= cfg_data;
        ipv6rlc_pkg::CFG_CLAIMS_ORDER:  claims_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // list accumulation
  always_comb begin
    saw_bad_nxt   = saw_bad_r;
    first_bad_nxt = first_bad_r;
    ordered_nxt   = ordered_r;
    total_nxt     = total_r;
    count_nxt     = count_r;
    if (take) begin
      if (pop_item.bad && !saw_bad_r) begin
        saw_bad_nxt   = 1'b1;
        first_bad_nxt = count_r;
      end
      if (pop_item.disorder) begin
        ordered_nxt = 1'b0;
      end
      total_nxt = total_r + pop_item.size;
      if (count_r != '1) begin
        count_nxt = count_r + IW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r     <= '0;
      count_r     <= '0;
      first_bad_r <= '0;
      saw_bad_r   <= 1'b0;
      ordered_r   <= 1'b1;
    end else if (finish) begin
      total_r     <= '0;
      count_r     <= '0;
      first_bad_r <= '0;
      saw_bad_r   <= 1'b0;
      ordered_r   <= 1'b1;
    end else begin
      total_r     <= total_nxt;
      count_r     <= count_nxt;
      first_bad_r <= first_bad_nxt;
      saw_bad_r   <= saw_bad_nxt;
      ordered_r   <= ordered_nxt;
    end
  end

  // snapshot of a finished list
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      snap_valid_r <= 1'b0;
    end else if (snap_ready) begin
      snap_valid_r <= finish;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      snap_total_r     <= total_nxt;
      snap_first_bad_r <= first_bad_nxt;
      snap_saw_bad_r   <= saw_bad_nxt;
      snap_ordered_r   <= ordered_nxt;
    end
  end

  // status
  always_comb begin
    out_data_nxt.status       = ipv6rlc_pkg::STATUS_OK;
    out_data_nxt.bad_index    = '0;
    out_data_nxt.list_ordered = 1'b1;
    if (snap_saw_bad_r) begin
      out_data_nxt.status    = ipv6rlc_pkg::STATUS_BAD_RANGE;
      out_data_nxt.bad_index = snap_first_bad_r;
    end else begin
      out_data_nxt.list_ordered = snap_ordered_r;
      if (snap_ordered_r && (snap_total_r != {exp_high_r, exp_low_r})) begin
        out_data_nxt.status = ipv6rlc_pkg::STATUS_MISMATCH;
      end else if (claims_r && !snap_ordered_r) begin
        out_data_nxt.status = ipv6rlc_pkg::STATUS_UNORDERED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ready) begin
      out_valid_r <= snap_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && snap_valid_r) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

>>> src/ipv6rlc_checker.sv
// ----------------------------------------------------------------------------
// ipv6rlc_checker
// Port-level checks of the range list checker, bound to the top level.
// ----------------------------------------------------------------------------
module ipv6rlc_checker (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_valid,
  input logic                   out_stall,
  input ipv6rlc_pkg::out_item_t out_data
);

  // stalled beat holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output beat changed under stall");

  // bad range reports the list as ordered
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ipv6rlc_pkg::STATUS_BAD_RANGE)
      |-> out_data.list_ordered)
    else $error("bad range status without list_ordered");

  // index only for bad range
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != ipv6rlc_pkg::STATUS_BAD_RANGE)
      |-> (out_data.bad_index == '0))
    else $error("bad_index set without bad range status");

  // mismatch only judged on an ordered list
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ipv6rlc_pkg::STATUS_MISMATCH)
      |-> out_data.list_ordered)
    else $error("count mismatch on unordered list");

  // unordered status agrees with the order flag
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ipv6rlc_pkg::STATUS_UNORDERED)
      |-> !out_data.list_ordered)
    else $error("unordered status on ordered list");

endmodule

bind ipv6_range_list_checker_top ipv6rlc_checker u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

>>> tb/tb_ipv6_range_list_checker_top.sv
// ----------------------------------------------------------------------------
// tb_ipv6_range_list_checker_top
// Self-checking bench for the IPv6 range list checker. A short directed table
// covers the extremes of the address fields and every status code. Random lists
// follow, mostly sorted and disjoint, some with an adjacent, overlapping or
// reversed record, and some pure noise. Every status beat is compared with the
// table's result or a cycle-free rule model, under shifting idle and stall pressure.
// ----------------------------------------------------------------------------
module tb_ipv6_range_list_checker_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [127:0] ALL_ONES = '1;
  localparam logic [ipv6rlc_pkg::CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int RANDOM_BEATS = 850;
  localparam int MAX_SHOWN = 10;

  typedef struct {
    bit                                  is_cfg;
    logic [ipv6rlc_pkg::CFG_INDEX_W-1:0] idx;
    logic [63:0]                         data;
    ipv6rlc_pkg::in_item_t               beat;
    bit                                  typed;
    ipv6rlc_pkg::out_item_t              res;
  } dir_row_t;

  logic                                clk = 1'b0;
  logic                                rst_n = 1'b0;
  logic                                cfg_we = 1'b0;
  logic [ipv6rlc_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [ipv6rlc_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
  logic                                in_valid = 1'b0;
  logic                                in_stall;
  ipv6rlc_pkg::in_item_t               in_data = '0;
  logic                                out_valid;
  logic                                out_stall = 1'b0;
  ipv6rlc_pkg::out_item_t              out_data;

  int idle_pct = 0;
  int stall_pct = 0;
  int errors = 0;
  int beats_sent = 0;
  bit cur_typed = 1'b0;
  ipv6rlc_pkg::out_item_t cur_res = '0;

  // list model state
  logic [127:0] want_total = '0;
  logic         claim_order = 1'b0;
  logic [127:0] prev_end = '0;
  logic [127:0] addr_total = '0;
  logic [31:0]  rec_count = '0;
  logic [31:0]  first_bad = '0;
  logic         bad_seen = 1'b0;
  logic         in_order = 1'b1;
  logic         has_prev = 1'b0;

  ipv6rlc_pkg::out_item_t status_q[$];
  dir_row_t               dir_rows[$];
  ipv6rlc_pkg::in_item_t  list_q[$];

  ipv6_range_list_checker_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [127:0] rand128();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  function automatic logic [127:0] rand_span();
    case ($urandom_range(0, 3))
      0: return {96'd0, $urandom_range(0, 15)};
      1: return {96'd0, $urandom};
      2: return {64'd0, $urandom, $urandom};
      default: return rand128() >> $urandom_range(1, 127);
    endcase
  endfunction

  function automatic ipv6rlc_pkg::in_item_t make_beat(logic [127:0] s, logic [127:0] e,
                                                      logic norec, logic fin);
    ipv6rlc_pkg::in_item_t b;
    b.start_high = s[127:64];
    b.start_low  = s[63:0];
    b.end_high   = e[127:64];
    b.end_low    = e[63:0];
    b.no_record  = norec;
    b.final_item = fin;
    return b;
  endfunction

  function automatic void add_beat(logic [127:0] s, logic [127:0] e, logic norec, logic fin);
    dir_row_t r;
    r = '{default: '0};
    r.beat = make_beat(s, e, norec, fin);
    dir_rows.push_back(r);
  endfunction

  function automatic void add_cfg(logic [ipv6rlc_pkg::CFG_INDEX_W-1:0] idx,
                                  logic [63:0] data);
    dir_row_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.data = data;
    dir_rows.push_back(r);
  endfunction

  function automatic void set_res(logic [1:0] st, logic [31:0] idx, logic ord);
    dir_row_t r;
    r = dir_rows.pop_back();
    r.typed = 1'b1;
    r.res.status = st;
    r.res.bad_index = idx;
    r.res.list_ordered = ord;
    dir_rows.push_back(r);
  endfunction

  task automatic score_beat(input ipv6rlc_pkg::in_item_t b);
    logic [127:0] s;
    logic [127:0] e;
    ipv6rlc_pkg::out_item_t r;
    s = {b.start_high, b.start_low};
    e = {b.end_high, b.end_low};
    if (!b.no_record) begin
      if (e < s && !bad_seen) begin
        bad_seen = 1'b1;
        first_bad = rec_count;
      end
      if (has_prev && (s <= prev_end || (prev_end != ALL_ONES && s == prev_end + 128'd1)))
        in_order = 1'b0;
      addr_total = addr_total + (e - s + 128'd1);
      prev_end = e;
      has_prev = 1'b1;
      if (rec_count != '1) rec_count = rec_count + 32'd1;
    end
    if (b.final_item) begin
      r.status = ipv6rlc_pkg::STATUS_OK;
      r.bad_index = '0;
      r.list_ordered = 1'b1;
      if (bad_seen) begin
        r.status = ipv6rlc_pkg::STATUS_BAD_RANGE;
        r.bad_index = first_bad;
      end else begin
        r.list_ordered = in_order;
        if (in_order && addr_total != want_total) r.status = ipv6rlc_pkg::STATUS_MISMATCH;
        else if (claim_order && !in_order) r.status = ipv6rlc_pkg::STATUS_UNORDERED;
      end
      status_q.push_back(cur_typed ? cur_res : r);
      prev_end = '0;
      addr_total = '0;
      rec_count = '0;
      first_bad = '0;
      bad_seen = 1'b0;
      in_order = 1'b1;
      has_prev = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    ipv6rlc_pkg::out_item_t exp_r;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (status_q.size() == 0) begin
          if (errors < MAX_SHOWN)
            $display("unexpected status beat: status %0d index %0d ordered %0b",
                     out_data.status, out_data.bad_index, out_data.list_ordered);
          errors++;
        end else begin
          exp_r = status_q.pop_front();
          if (out_data.status !== exp_r.status || out_data.bad_index !== exp_r.bad_index ||
              out_data.list_ordered !== exp_r.list_ordered) begin
            if (errors < MAX_SHOWN)
              $display("status beat mismatch: expected %0d/%0d/%0b, got %0d/%0d/%0b",
                       exp_r.status, exp_r.bad_index, exp_r.list_ordered,
                       out_data.status, out_data.bad_index, out_data.list_ordered);
            errors++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          ipv6rlc_pkg::CFG_EXPECTED_LOW:  want_total[63:0] = cfg_data;
          ipv6rlc_pkg::CFG_EXPECTED_HIGH: want_total[127:64] = cfg_data;
          ipv6rlc_pkg::CFG_CLAIMS_ORDER:  claim_order = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) score_beat(in_data);
    end
  end

  always @(negedge clk) out_stall <= ($urandom_range(0, 99) < stall_pct);

  task automatic push_beat(input ipv6rlc_pkg::in_item_t b, input bit typed,
                           input ipv6rlc_pkg::out_item_t res);
    while ($urandom_range(0, 99) < idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= b;
    cur_typed = typed;
    cur_res = res;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ipv6rlc_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [63:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int kind;
    int len;
    int flaw;
    int flaw_kind;
    int lists;
    logic [127:0] base;
    logic [127:0] s;
    logic [127:0] e;
    logic [127:0] pe;
    logic [127:0] tot;
    logic [127:0] want;
    logic [128:0] nxt;
    logic [63:0]  d;

    // empty list, then single records against the reset totals
    add_beat(rand128(), rand128(), 1'b1, 1'b1); set_res(ipv6rlc_pkg::STATUS_OK, 0, 1'b1);
    add_beat(0, 0, 1'b0, 1'b1);        set_res(ipv6rlc_pkg::STATUS_MISMATCH, 0, 1'b1);
    add_beat(1, 0, 1'b0, 1'b1);        set_res(ipv6rlc_pkg::STATUS_BAD_RANGE, 0, 1'b1);
    add_beat(0, ALL_ONES, 1'b0, 1'b1); set_res(ipv6rlc_pkg::STATUS_OK, 0, 1'b1);
    add_beat(0, 5, 1'b0, 1'b0);
    add_beat(10, 20, 1'b0, 1'b0);
    add_beat(30, ALL_ONES, 1'b0, 1'b1);
    // adjacent and overlapping neighbors
    add_beat(0, 5, 1'b0, 1'b0);
    add_beat(6, 9, 1'b0, 1'b1);        set_res(ipv6rlc_pkg::STATUS_OK, 0, 1'b0);
    add_beat(0, 5, 1'b0, 1'b0);
    add_beat(5, 9, 1'b0, 1'b1);        set_res(ipv6rlc_pkg::STATUS_OK, 0, 1'b0);
    add_beat(0, 1, 1'b0, 1'b0);
    add_beat(20, 10, 1'b0, 1'b0);
    add_beat(30, 40, 1'b0, 1'b1);      set_res(ipv6rlc_pkg::STATUS_BAD_RANGE, 1, 1'b1);
    add_cfg(ipv6rlc_pkg::CFG_CLAIMS_ORDER, '1);
    add_beat(10, 20, 1'b0, 1'b0);
    add_beat(0, 5, 1'b0, 1'b1);        set_res(ipv6rlc_pkg::STATUS_UNORDERED, 0, 1'b0);
    // range ending at the top address followed by a wrap to zero
    add_beat(ALL_ONES - 7, ALL_ONES, 1'b0, 1'b0);
    add_beat(0, 0, 1'b0, 1'b1);        set_res(ipv6rlc_pkg::STATUS_UNORDERED, 0, 1'b0);
    add_beat(0, 3, 1'b0, 1'b0);
    add_beat(rand128(), rand128(), 1'b1, 1'b0);
    add_beat(8, 9, 1'b0, 1'b1);
    add_cfg(ipv6rlc_pkg::CFG_EXPECTED_LOW, 64'd4);
    add_beat(0, 3, 1'b0, 1'b0);
    add_beat(rand128(), rand128(), 1'b1, 1'b1); set_res(ipv6rlc_pkg::STATUS_OK, 0, 1'b1);
    add_cfg(ipv6rlc_pkg::CFG_EXPECTED_LOW, '0);
    add_cfg(ipv6rlc_pkg::CFG_EXPECTED_HIGH, 64'd1);
    add_beat(0, {64'd0, 64'hFFFF_FFFF_FFFF_FFFF}, 1'b0, 1'b1);
    set_res(ipv6rlc_pkg::STATUS_OK, 0, 1'b1);
    add_beat({64'd0, 64'hFFFF_FFFF_FFFF_FFFF}, {64'd1, 64'd0}, 1'b0, 1'b1);
    add_cfg(ipv6rlc_pkg::CFG_EXPECTED_LOW, '1);
    add_cfg(ipv6rlc_pkg::CFG_EXPECTED_HIGH, '1);
    add_beat(1, ALL_ONES, 1'b0, 1'b1); set_res(ipv6rlc_pkg::STATUS_OK, 0, 1'b1);
    add_cfg(CFG_UNUSED, {$urandom, $urandom});
    add_cfg(ipv6rlc_pkg::CFG_CLAIMS_ORDER, 64'hFFFF_FFFF_FFFF_FFFE);
    add_beat(0, 5, 1'b0, 1'b0);
    add_beat(6, 9, 1'b0, 1'b1);        set_res(ipv6rlc_pkg::STATUS_OK, 0, 1'b0);

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        settle();
        write_reg(dir_rows[i].idx, dir_rows[i].data);
      end else begin
        push_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].res);
      end
    end

    beats_sent = 0;
    lists = 0;
    while (beats_sent < RANDOM_BEATS) begin
      if (lists % 6 == 0) begin
        case ((lists / 6) % 4)
          0: begin idle_pct = 0;  stall_pct = 0;  end
          1: begin idle_pct = 51; stall_pct = 0;  end
          2: begin idle_pct = 0;  stall_pct = 51; end
          default: begin idle_pct = 31; stall_pct = 31; end
        endcase
      end

      list_q.delete();
      kind = $urandom_range(0, 19);
      len = $urandom_range(1, 10);
      if (kind == 0) begin
        list_q.push_back(make_beat(rand128(), rand128(), 1'b1, 1'b1));
      end else if (kind <= 2) begin
        for (int i = 0; i < len; i++)
          list_q.push_back(make_beat(rand128(), rand128(), $urandom_range(0, 7) == 0,
                                     i == len - 1));
      end else begin
        flaw = (kind <= 6) ? $urandom_range(0, len - 1) : -1;
        flaw_kind = $urandom_range(0, 2);
        base = rand128() >> $urandom_range(0, 127);
        pe = '0;
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 9) == 0)
            list_q.push_back(make_beat(rand128(), rand128(), 1'b1, 1'b0));
          if (i == 0) begin
            s = base;
          end else if (i == flaw && flaw_kind == 1) begin
            s = pe >> $urandom_range(0, 2);
          end else begin
            nxt = {1'b0, pe} + ((i == flaw && flaw_kind == 0) ? 129'd1
                                                              : 129'd2 + {1'b0, rand_span()});
            if (nxt[128]) break;
            s = nxt[127:0];
          end
          nxt = {1'b0, s} + {1'b0, rand_span()};
          e = nxt[128] ? ALL_ONES : nxt[127:0];
          if (i == flaw && flaw_kind == 2) begin
            if (e != s) {s, e} = {e, s};
            else if (s != '0) e = s - 128'd1;
            else begin
              s = 128'd1;
              e = '0;
            end
          end
          list_q.push_back(make_beat(s, e, 1'b0, 1'b0));
          pe = e;
        end
        if ($urandom_range(0, 4) == 0)
          list_q.push_back(make_beat(rand128(), rand128(), 1'b1, 1'b1));
        else
          list_q[list_q.size() - 1].final_item = 1'b1;
      end

      if ($urandom_range(0, 1) == 0) begin
        tot = '0;
        foreach (list_q[i])
          if (!list_q[i].no_record)
            tot = tot + ({list_q[i].end_high, list_q[i].end_low} -
                         {list_q[i].start_high, list_q[i].start_low} + 128'd1);
        case ($urandom_range(0, 9))
          0: want = rand128();
          1: want = tot ^ (128'd1 << $urandom_range(0, 127));
          default: want = tot;
        endcase
        settle();
        if ($urandom_range(0, 1) == 0) begin
          write_reg(ipv6rlc_pkg::CFG_EXPECTED_LOW, want[63:0]);
          write_reg(ipv6rlc_pkg::CFG_EXPECTED_HIGH, want[127:64]);
        end else begin
          write_reg(ipv6rlc_pkg::CFG_EXPECTED_HIGH, want[127:64]);
          write_reg(ipv6rlc_pkg::CFG_EXPECTED_LOW, want[63:0]);
        end
        d = {$urandom, $urandom};
        d[0] = ($urandom_range(0, 1) == 0);
        write_reg(ipv6rlc_pkg::CFG_CLAIMS_ORDER, d);
        if ($urandom_range(0, 7) == 0) write_reg(CFG_UNUSED, {$urandom, $urandom});
      end

      foreach (list_q[i]) push_beat(list_q[i], 1'b0, '0);
      lists++;
    end

    settle();
    repeat (4) @(posedge clk);
    if (errors == 0 && status_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/ipv6rlc_pkg.sv
src/ipv6rlc_front.sv
src/ipv6rlc_queue.sv
src/ipv6rlc_back.sv
src/ipv6_range_list_checker_top.sv
src/ipv6rlc_checker.sv
tb/tb_ipv6_range_list_checker_top.sv
